// ===== rtl/median_filter_3x3_top_macros.svh =====
// Assertion helpers for the checker file.
`ifndef MEDIAN_FILTER_3X3_TOP_MACROS_SVH
`define MEDIAN_FILTER_3X3_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MF3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mf3_pkg.sv =====
package mf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 8;

    localparam int DIM_BITS   = 11;
    localparam int DIM_RESET  = 1024;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);

    localparam int RES_DEPTH    = 8;
    localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
    localparam int RES_CNT_BITS = RES_PTR_BITS + 1;

    localparam logic FUNC_DRAIN = 1'b1;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [DIM_BITS-1:0]   dim_t;
    typedef logic [COL_BITS-1:0]   col_t;

    typedef enum logic [0:0] {
        CFG_HEIGHT = 1'b0,
        CFG_WIDTH  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic   func;
        pixel_t pixel;
    } item_t;

    typedef struct packed {
        pixel_t median_value;
        logic   frame_last;
    } result_t;

    // one column of the window, index 0 is the top
    typedef pixel_t [2:0] trio_t;
    typedef trio_t  [2:0] nine_t;

    function automatic dim_t clamp_dim(dim_t v, int hi);
        dim_t r;
        if (v == '0)
            r = DIM_BITS'(1);
        else if (int'(v) > hi)
            r = DIM_BITS'(hi);
        else
            r = v;
        return r;
    endfunction

    function automatic trio_t sort3(trio_t v);
        pixel_t a;
        pixel_t b;
        pixel_t c;
        pixel_t t;
        trio_t  r;
        a = v[0];
        b = v[1];
        c = v[2];
        if (a > b)
        begin
            t = a; a = b; b = t;
        end
        if (b > c)
        begin
            t = b; b = c; c = t;
        end
        if (a > b)
        begin
            t = a; a = b; b = t;
        end
        r[0] = a;
        r[1] = b;
        r[2] = c;
        return r;
    endfunction

    function automatic pixel_t med3(pixel_t a, pixel_t b, pixel_t c);
        trio_t s;
        s = sort3({c, b, a});
        return s[1];
    endfunction

    function automatic pixel_t max3(pixel_t a, pixel_t b, pixel_t c);
        pixel_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic pixel_t min3(pixel_t a, pixel_t b, pixel_t c);
        pixel_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

// ===== rtl/median_filter_3x3_top.sv =====
// A result passes the accept, window, column-sort and merge registers and the result queue before it is offered.
// Throughput: one item per cycle while the result queue has room; a row-end item can give two
//   results, so the result channel (one transfer a cycle) sets the long-run pace, with an 8-entry result queue.
// The line stores sit in one 1024 x 16 RAM, read at accept; pixel items write back in the following cycle.
// Reset clears positions, window, pipeline and queue; sizes return to 1024 x 1024.
// RAM contents are not cleared; no clearing pass.
module median_filter_3x3_top
    import mf3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  dim_t       cfg_data
);

    typedef struct packed {
        logic   pix;
        col_t   addr;
        pixel_t px;
        logic   ge1;
        logic   ge2;
        logic   first;
        logic   emit_int;
        logic   emit_edge;
        logic   drain;
    } s1_t;

    typedef struct packed {
        logic  valid;
        logic  last;
        nine_t cols;
    } lane_t;

    typedef struct packed {
        logic   valid;
        logic   last;
        pixel_t lo;
        pixel_t mid;
        pixel_t hi;
    } lane3_t;

    logic run_reg;
    dim_t height_reg;
    dim_t width_reg;
    dim_t row_reg;
    dim_t row_next;
    dim_t colpos_reg;
    dim_t colpos_next;
    dim_t drain_reg;
    dim_t drain_next;

    logic accept;
    logic is_pix;
    logic row_done;
    logic active;
    dim_t pos;
    dim_t col;
    dim_t col_inc;
    col_t col_addr;
    logic last_col;
    logic emit;
    logic emit_int;
    logic emit_edge;
    logic [1:0] n_res;

    logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] mem_q_reg;
    logic                    fwd_hit_reg;
    logic [2*PIXEL_BITS-1:0] fwd_word_reg;

    logic s1_valid_reg;
    s1_t  s1_reg;
    s1_t  s1_next;

    logic [2*PIXEL_BITS-1:0] rd_word;
    logic [2*PIXEL_BITS-1:0] wr_word;
    logic                    s1_wr;
    pixel_t                  upper_raw;
    pixel_t                  lower_raw;
    trio_t                   cur;
    trio_t                   new_left;
    trio_t                   win_left_reg;
    trio_t                   win_mid_reg;

    lane_t  a2_reg;
    lane_t  b2_reg;
    lane_t  a3_reg;
    lane_t  b3_reg;
    lane3_t a4_reg;
    lane3_t b4_reg;

    result_t                 fifo [RES_DEPTH];
    result_t                 push_a;
    result_t                 push_b;
    logic [RES_PTR_BITS-1:0] wr_ptr_reg;
    logic [RES_PTR_BITS-1:0] rd_ptr_reg;
    logic [RES_CNT_BITS-1:0] cnt_reg;
    logic [RES_CNT_BITS-1:0] res_cnt_reg;
    logic [1:0]              n_push;
    logic                    out_fire;

    // config
    assign cfg_ready = run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            height_reg <= clamp_dim(DIM_BITS'(DIM_RESET), MAX_HEIGHT);
            width_reg  <= clamp_dim(DIM_BITS'(DIM_RESET), MAX_WIDTH);
        end
        else
        begin
            run_reg <= 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_HEIGHT: height_reg <= clamp_dim(cfg_data, MAX_HEIGHT);
                    CFG_WIDTH:  width_reg  <= clamp_dim(cfg_data, MAX_WIDTH);
                    default:    height_reg <= height_reg;
                endcase
            end
        end
    end

    // accept stage: positions, RAM read issue
    assign item_ready = run_reg && (res_cnt_reg <= RES_CNT_BITS'(RES_DEPTH - 2));
    assign accept     = item_valid && item_ready;
    assign is_pix     = (item.func != FUNC_DRAIN);
    assign row_done   = (row_reg >= height_reg);
    assign active     = is_pix ? !row_done : row_done;
    assign pos        = is_pix ? colpos_reg : drain_reg;
    assign col        = (int'(pos) >= MAX_WIDTH) ? DIM_BITS'(MAX_WIDTH - 1) : pos;
    assign col_inc    = col + DIM_BITS'(1);
    assign col_addr   = COL_BITS'(col);
    assign last_col   = (col_inc >= width_reg);
    assign emit       = active && (row_reg != '0);
    assign emit_int   = emit && (col != '0);
    assign emit_edge  = emit && last_col;
    assign n_res      = {1'b0, emit_int} + {1'b0, emit_edge};

    always_comb
    begin
        row_next    = row_reg;
        colpos_next = colpos_reg;
        drain_next  = drain_reg;
        if (accept && active)
        begin
            if (is_pix)
            begin
                if (last_col)
                begin
                    colpos_next = '0;
                    row_next    = row_reg + DIM_BITS'(1);
                end
                else
                begin
                    colpos_next = col_inc;
                end
            end
            else
            begin
                if (last_col)
                begin
                    row_next    = '0;
                    colpos_next = '0;
                    drain_next  = '0;
                end
                else
                begin
                    drain_next = col_inc;
                end
            end
        end
    end

    always_comb
    begin
        s1_next.pix       = is_pix;
        s1_next.addr      = col_addr;
        s1_next.px        = item.pixel;
        s1_next.ge1       = (row_reg >= DIM_BITS'(1));
        s1_next.ge2       = (row_reg >= DIM_BITS'(2));
        s1_next.first     = (col == '0);
        s1_next.emit_int  = emit_int;
        s1_next.emit_edge = emit_edge;
        s1_next.drain     = !is_pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            colpos_reg   <= '0;
            drain_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            colpos_reg   <= colpos_next;
            drain_reg    <= drain_next;
            s1_valid_reg <= accept && active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && active)
        begin
            s1_reg       <= s1_next;
            fwd_hit_reg  <= s1_wr && (s1_reg.addr == col_addr);
            fwd_word_reg <= wr_word;
        end
    end

    // line RAM: upper row in the high byte, lower row in the low byte
    always_ff @(posedge clk)
    begin
        if (s1_wr)
            line_mem[s1_reg.addr] <= wr_word;
        if (accept && active)
            mem_q_reg <= line_mem[col_addr];
    end

    // stage 1: write-back and window shift
    assign rd_word   = fwd_hit_reg ? fwd_word_reg : mem_q_reg;
    assign upper_raw = rd_word[2*PIXEL_BITS-1:PIXEL_BITS];
    assign lower_raw = rd_word[PIXEL_BITS-1:0];
    assign wr_word   = {lower_raw, s1_reg.px};
    assign s1_wr     = s1_valid_reg && s1_reg.pix;

    always_comb
    begin
        cur[0]   = s1_reg.ge2 ? upper_raw : '0;
        cur[1]   = s1_reg.ge1 ? lower_raw : '0;
        cur[2]   = s1_reg.pix ? s1_reg.px : '0;
        new_left = s1_reg.first ? '0 : win_mid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg <= '0;
            win_mid_reg  <= '0;
            a2_reg       <= '0;
            b2_reg       <= '0;
            a3_reg       <= '0;
            b3_reg       <= '0;
            a4_reg       <= '0;
            b4_reg       <= '0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                win_left_reg <= new_left;
                win_mid_reg  <= cur;
            end
            a2_reg.valid <= s1_valid_reg && s1_reg.emit_int;
            a2_reg.last  <= 1'b0;
            a2_reg.cols  <= {cur, win_mid_reg, win_left_reg};
            b2_reg.valid <= s1_valid_reg && s1_reg.emit_edge;
            b2_reg.last  <= s1_reg.drain;
            b2_reg.cols  <= {trio_t'('0), cur, new_left};

            // stage 2: sort each column
            a3_reg.valid   <= a2_reg.valid;
            a3_reg.last    <= a2_reg.last;
            b3_reg.valid   <= b2_reg.valid;
            b3_reg.last    <= b2_reg.last;
            for (int i = 0; i < 3; i++)
            begin
                a3_reg.cols[i] <= sort3(a2_reg.cols[i]);
                b3_reg.cols[i] <= sort3(b2_reg.cols[i]);
            end

            // stage 3: max of minima, median of middles, min of maxima
            a4_reg.valid <= a3_reg.valid;
            a4_reg.last  <= a3_reg.last;
            a4_reg.lo    <= max3(a3_reg.cols[0][0], a3_reg.cols[1][0], a3_reg.cols[2][0]);
            a4_reg.mid   <= med3(a3_reg.cols[0][1], a3_reg.cols[1][1], a3_reg.cols[2][1]);
            a4_reg.hi    <= min3(a3_reg.cols[0][2], a3_reg.cols[1][2], a3_reg.cols[2][2]);
            b4_reg.valid <= b3_reg.valid;
            b4_reg.last  <= b3_reg.last;
            b4_reg.lo    <= max3(b3_reg.cols[0][0], b3_reg.cols[1][0], b3_reg.cols[2][0]);
            b4_reg.mid   <= med3(b3_reg.cols[0][1], b3_reg.cols[1][1], b3_reg.cols[2][1]);
            b4_reg.hi    <= min3(b3_reg.cols[0][2], b3_reg.cols[1][2], b3_reg.cols[2][2]);
        end
    end

    // stage 4: final median into the result queue, interior result first
    assign push_a.median_value = med3(a4_reg.lo, a4_reg.mid, a4_reg.hi);
    assign push_a.frame_last   = a4_reg.last;
    assign push_b.median_value = med3(b4_reg.lo, b4_reg.mid, b4_reg.hi);
    assign push_b.frame_last   = b4_reg.last;
    assign n_push              = {1'b0, a4_reg.valid} + {1'b0, b4_reg.valid};

    assign result_valid = (cnt_reg != '0);
    assign result       = fifo[rd_ptr_reg];
    assign out_fire     = result_valid && result_ready;

    always_ff @(posedge clk)
    begin
        if (a4_reg.valid)
            fifo[wr_ptr_reg] <= push_a;
        if (b4_reg.valid)
            fifo[a4_reg.valid ? wr_ptr_reg + RES_PTR_BITS'(1) : wr_ptr_reg] <= push_b;
    end

    // res_cnt counts queued results plus those still in the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_reg + RES_PTR_BITS'(n_push);
            rd_ptr_reg  <= rd_ptr_reg + RES_PTR_BITS'(out_fire);
            cnt_reg     <= cnt_reg + RES_CNT_BITS'(n_push) - RES_CNT_BITS'(out_fire);
            res_cnt_reg <= res_cnt_reg + (accept ? RES_CNT_BITS'(n_res) : '0)
                           - RES_CNT_BITS'(out_fire);
        end
    end

endmodule

// ===== rtl/mf3_chk.sv =====
`include "median_filter_3x3_top_macros.svh"

module mf3_chk
    import mf3_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    `MF3_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped before transfer")
    `MF3_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result), "result changed while stalled")
    // an empty queue only refills from an item that was taken and has passed through the pipeline
    `MF3_ASSERT_NOW(a_result_latency, $rose(result_valid), $past(item_valid && item_ready, 5), "result without a matching item transfer")
    `MF3_ASSERT_NOW(a_last_from_drain, $rose(result_valid) && result.frame_last, $past(item.func, 5) == FUNC_DRAIN, "frame end not caused by a drain item")

endmodule

bind median_filter_3x3_top mf3_chk u_mf3_chk (.*);
